// ===== design/assert_macros.svh =====
// Assertion macros for the pressure compensation depth core.
// Every macro samples on clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every clock edge.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Consequence that holds in the same cycle as its antecedent.
`define ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== design/pcd_pkg.sv =====
// Package for the pressure compensation depth core: widths, constants,
// status and register codes, and the structs passed between pipeline parts.
package pcd_pkg;

   localparam int RAW_W       = 24;
   localparam int COEF_W      = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int STATUS_W    = 2;

   localparam int DT_W        = 25;
   localparam int TPROD_W     = 42;
   localparam int TEMP_W      = 19;
   localparam int OFF_W       = 36;
   localparam int SENS_W      = 35;
   localparam int SLO_W       = 17;
   localparam int LOPP_W      = 41;
   localparam int HIPP_W      = 43;
   localparam int FULL_W      = 60;
   localparam int P_W         = 40;
   localparam int PEXT_W      = 56;
   localparam int PM_W        = 42;
   localparam int MPA_W       = 32;
   localparam int AIRK_W      = 24;
   localparam int AIRP_W      = 57;
   localparam int AIRS_W      = 31;
   localparam int RECIP_SHIFT = 44;
   localparam int RECIP_W     = 31;
   localparam int WPROD_W     = 62;
   localparam int QUOT_W      = 18;
   localparam int QM_W        = 32;
   localparam int DIV_W       = 14;

   localparam int COMP_STAGES  = 6;
   localparam int SCALE_STAGES = 2;
   localparam int DEPTH_STAGES = 4;

   localparam logic signed [TEMP_W-1:0] TEMP_BIAS           = 19'sd2000;
   localparam logic signed [PM_W-1:0]   LOW_RANGE_LIMIT_MPA = 42'sd130000000;
   localparam logic signed [MPA_W-1:0]  ATMO_MPA            = 32'sd101325000;
   localparam logic signed [AIRK_W-1:0] AIR_A               = -24'sd5588586;
   localparam logic signed [AIRP_W-1:0] AIR_B               = 57'sd566263523658885;
   localparam logic [DIV_W-1:0]         WATER_DIV           = 14'd10091;
   localparam logic [RECIP_W-1:0]       WATER_RECIP         =
      RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd10091);

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ZERO = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVER = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_SENS        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SENS_TEMP   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_TEMP = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_TREF        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TEMP_SENS   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MODE        = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_PRESS_OFF   = 3'd7;

   typedef struct packed {
      logic [COEF_W-1:0]       sens_coef;
      logic [COEF_W-1:0]       offset_coef;
      logic [COEF_W-1:0]       sens_temp_coef;
      logic [COEF_W-1:0]       offset_temp_coef;
      logic [COEF_W-1:0]       tref_coef;
      logic [COEF_W-1:0]       temp_sens_coef;
      logic                    sensor_mode;
      logic signed [MPA_W-1:0] pressure_offset_mpa;
   } cfg_type;

   typedef struct packed {
      logic                     zero;
      logic signed [TEMP_W-1:0] temp;
      logic signed [P_W-1:0]    p;
   } comp_out_type;

   typedef struct packed {
      logic                     zero;
      logic                     over;
      logic signed [TEMP_W-1:0] temp;
      logic signed [MPA_W-1:0]  pr;
   } scale_out_type;

endpackage

// ===== design/pcd_comp.sv =====
// First-order compensation pipeline: temperature, offset, sensitivity and
// compensated pressure over six register stages. Depends on pcd_pkg.
module pcd_comp
   import pcd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [RAW_W-1:0]   raw_pressure,
   input  logic [RAW_W-1:0]   raw_temperature,
   output logic               out_valid,
   input  logic               out_ready,
   output comp_out_type       out_data
);

   logic [COMP_STAGES-1:0] valid_ff;
   logic [COMP_STAGES-1:0] valid_in;
   logic [COMP_STAGES:0]   ready;

   logic signed [DT_W-1:0]    dt1_ff;
   logic signed [DT_W-1:0]    dt1_in;
   logic                      zero1_ff, zero2_ff, zero3_ff, zero4_ff, zero5_ff, zero6_ff;
   logic [RAW_W-1:0]          d1_1_ff, d1_2_ff, d1_3_ff;

   logic signed [TPROD_W-1:0] tprod2_ff, oprod2_ff, sprod2_ff;
   logic signed [TPROD_W-1:0] tprod_in, oprod_in, sprod_in;

   logic signed [TEMP_W-1:0]  temp3_ff, temp4_ff, temp5_ff, temp6_ff;
   logic signed [TEMP_W-1:0]  temp_in;
   logic signed [OFF_W-1:0]   off3_ff, off4_ff, off5_ff;
   logic signed [OFF_W-1:0]   off_in;
   logic signed [SENS_W-1:0]  sens3_ff;
   logic signed [SENS_W-1:0]  sens_in;

   logic [LOPP_W-1:0]         lopp4_ff;
   logic [LOPP_W-1:0]         lopp_in;
   logic signed [HIPP_W-1:0]  hipp4_ff;
   logic signed [HIPP_W-1:0]  hipp_in;

   logic signed [FULL_W-1:0]  full5_ff;
   logic signed [FULL_W-1:0]  full_in;

   logic signed [P_W-1:0]     p6_ff;
   logic signed [P_W-1:0]     p_in;

   always_comb begin
      ready[COMP_STAGES] = out_ready;
      for (int i = COMP_STAGES - 1; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
   end

   assign valid_in = {valid_ff[COMP_STAGES-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < COMP_STAGES; i++) begin
            if (ready[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   assign dt1_in   = $signed({1'b0, raw_temperature}) - $signed({1'b0, cfg.tref_coef, 8'd0});
   assign tprod_in = dt1_ff * $signed({1'b0, cfg.temp_sens_coef});
   assign oprod_in = dt1_ff * $signed({1'b0, cfg.offset_temp_coef});
   assign sprod_in = dt1_ff * $signed({1'b0, cfg.sens_temp_coef});
   assign temp_in  = TEMP_W'(tprod2_ff >>> 23) + TEMP_BIAS;
   assign off_in   = $signed({4'd0, cfg.offset_coef, 16'd0}) + OFF_W'(oprod2_ff >>> 7);
   assign sens_in  = $signed({4'd0, cfg.sens_coef, 15'd0}) + SENS_W'(sprod2_ff >>> 8);
   assign lopp_in  = LOPP_W'(sens3_ff[SLO_W-1:0]) * LOPP_W'(d1_3_ff);
   assign hipp_in  = $signed(sens3_ff[SENS_W-1:SLO_W]) * $signed({1'b0, d1_3_ff});
   assign full_in  = (FULL_W'(hipp4_ff) <<< SLO_W)
                   + $signed({{(FULL_W-LOPP_W){1'b0}}, lopp4_ff});
   assign p_in     = P_W'(full5_ff >>> 21) - P_W'(off5_ff);

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         dt1_ff  <= dt1_in;
         zero1_ff <= (raw_pressure == '0) || (raw_temperature == '0);
         d1_1_ff <= raw_pressure;
      end
      if (ready[1]) begin
         tprod2_ff <= tprod_in;
         oprod2_ff <= oprod_in;
         sprod2_ff <= sprod_in;
         zero2_ff  <= zero1_ff;
         d1_2_ff   <= d1_1_ff;
      end
      if (ready[2]) begin
         temp3_ff <= temp_in;
         off3_ff  <= off_in;
         sens3_ff <= sens_in;
         zero3_ff <= zero2_ff;
         d1_3_ff  <= d1_2_ff;
      end
      if (ready[3]) begin
         lopp4_ff <= lopp_in;
         hipp4_ff <= hipp_in;
         off4_ff  <= off3_ff;
         temp4_ff <= temp3_ff;
         zero4_ff <= zero3_ff;
      end
      if (ready[4]) begin
         full5_ff <= full_in;
         off5_ff  <= off4_ff;
         temp5_ff <= temp4_ff;
         zero5_ff <= zero4_ff;
      end
      if (ready[5]) begin
         p6_ff    <= p_in;
         temp6_ff <= temp5_ff;
         zero6_ff <= zero5_ff;
      end
   end

   assign in_ready      = ready[0];
   assign out_valid     = valid_ff[COMP_STAGES-1];
   assign out_data.zero = zero6_ff;
   assign out_data.temp = temp6_ff;
   assign out_data.p    = p6_ff;

endmodule

// ===== design/pcd_scale.sv =====
// Millipascal scaling per sensor range, low range limit check and high range
// offset, over two register stages. Depends on pcd_pkg.
module pcd_scale
   import pcd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          in_valid,
   output logic          in_ready,
   input  comp_out_type  in_data,
   output logic          out_valid,
   input  logic          out_ready,
   output scale_out_type out_data
);

   logic [SCALE_STAGES-1:0] valid_ff;
   logic [SCALE_STAGES-1:0] valid_in;
   logic [SCALE_STAGES:0]   ready;

   logic signed [PEXT_W-1:0] pext;
   logic signed [PEXT_W-1:0] prod_hi;
   logic signed [PEXT_W-1:0] prod_lo;
   logic signed [PM_W-1:0]   pm_in;
   logic signed [PM_W-1:0]   pm1_ff;
   logic signed [TEMP_W-1:0] temp1_ff;
   logic                     zero1_ff;
   logic signed [MPA_W-1:0]  pr_in;
   logic                     over_in;
   scale_out_type            out2_ff;

   always_comb begin
      ready[SCALE_STAGES] = out_ready;
      for (int i = SCALE_STAGES - 1; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
   end

   assign valid_in = {valid_ff[SCALE_STAGES-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < SCALE_STAGES; i++) begin
            if (ready[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   // times 10000 and times 1000 as shift and add
   assign pext    = PEXT_W'(in_data.p);
   assign prod_hi = (pext <<< 13) + (pext <<< 10) + (pext <<< 9) + (pext <<< 8) + (pext <<< 4);
   assign prod_lo = (pext <<< 10) - (pext <<< 4) - (pext <<< 3);
   assign pm_in   = cfg.sensor_mode ? PM_W'(prod_hi >>> 13) : PM_W'(prod_lo >>> 15);

   assign over_in = !cfg.sensor_mode && (pm1_ff > LOW_RANGE_LIMIT_MPA);
   assign pr_in   = cfg.sensor_mode ? MPA_W'(pm1_ff) + cfg.pressure_offset_mpa : MPA_W'(pm1_ff);

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         pm1_ff   <= pm_in;
         temp1_ff <= in_data.temp;
         zero1_ff <= in_data.zero;
      end
      if (ready[1]) begin
         out2_ff.zero <= zero1_ff;
         out2_ff.over <= over_in;
         out2_ff.temp <= temp1_ff;
         out2_ff.pr   <= pr_in;
      end
   end

   assign in_ready  = ready[0];
   assign out_valid = valid_ff[SCALE_STAGES-1];
   assign out_data  = out2_ff;

endmodule

// ===== design/pcd_depth.sv =====
// Depth conversion: linear air formula and seawater division by reciprocal
// multiply with one correction step, ending in the result register. Depends on pcd_pkg.
module pcd_depth
   import pcd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  scale_out_type            in_data,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [STATUS_W-1:0]      out_status,
   output logic signed [TEMP_W-1:0] out_temperature_centi,
   output logic signed [MPA_W-1:0]  out_pressure_mpa,
   output logic signed [MPA_W-1:0]  out_depth_mm
);

   logic [DEPTH_STAGES-1:0] valid_ff;
   logic [DEPTH_STAGES-1:0] valid_in;
   logic [DEPTH_STAGES:0]   ready;

   scale_out_type            item1_ff, item2_ff, item3_ff;
   logic                     air1_ff, air2_ff, air3_ff;
   logic signed [MPA_W-1:0]  n1_ff, n2_ff, n3_ff;
   logic signed [MPA_W-1:0]  n_in;
   logic signed [AIRP_W-1:0] airp1_ff;
   logic signed [AIRP_W-1:0] airp_in;
   logic signed [AIRP_W-1:0] airsum;
   logic signed [AIRS_W-1:0] airs2_ff;
   logic [WPROD_W-1:0]       wprod2_ff;
   logic [WPROD_W-1:0]       wprod_in;
   logic [QUOT_W-1:0]        q0_in;
   logic [QUOT_W-1:0]        q0_3_ff;
   logic [QM_W-1:0]          qm3_ff;
   logic [QM_W-1:0]          qm_in;
   logic signed [MPA_W-1:0]  dair3_ff;
   logic [QM_W-1:0]          rem;
   logic [QUOT_W-1:0]        quot;
   logic signed [MPA_W-1:0]  depth_sel;

   logic [STATUS_W-1:0]      status_ff;
   logic signed [TEMP_W-1:0] temp_ff;
   logic signed [MPA_W-1:0]  press_ff;
   logic signed [MPA_W-1:0]  depth_ff;

   always_comb begin
      ready[DEPTH_STAGES] = out_ready;
      for (int i = DEPTH_STAGES - 1; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
   end

   assign valid_in = {valid_ff[DEPTH_STAGES-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < DEPTH_STAGES; i++) begin
            if (ready[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   assign n_in     = in_data.pr - ATMO_MPA;
   assign airp_in  = in_data.pr * AIR_A;
   assign wprod_in = WPROD_W'(n1_ff[MPA_W-2:0]) * WPROD_W'(WATER_RECIP);
   assign airsum   = airp1_ff + AIR_B;
   assign q0_in    = wprod2_ff[WPROD_W-1:RECIP_SHIFT];
   assign qm_in    = QM_W'(q0_in) * QM_W'(WATER_DIV);
   assign rem      = QM_W'(n3_ff[MPA_W-2:0]) - qm3_ff;
   assign quot     = (rem >= QM_W'(WATER_DIV)) ? q0_3_ff + QUOT_W'(1) : q0_3_ff;
   assign depth_sel = air3_ff ? dair3_ff : $signed({{(MPA_W-QUOT_W){1'b0}}, quot});

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         item1_ff <= in_data;
         air1_ff  <= in_data.pr < ATMO_MPA;
         n1_ff    <= n_in;
         airp1_ff <= airp_in;
      end
      if (ready[1]) begin
         item2_ff  <= item1_ff;
         air2_ff   <= air1_ff;
         n2_ff     <= n1_ff;
         airs2_ff  <= AIRS_W'(airsum >>> 26);
         wprod2_ff <= wprod_in;
      end
      if (ready[2]) begin
         item3_ff <= item2_ff;
         air3_ff  <= air2_ff;
         n3_ff    <= n2_ff;
         q0_3_ff  <= q0_in;
         qm3_ff   <= qm_in;
         dair3_ff <= -MPA_W'(airs2_ff);
      end
      if (ready[3]) begin
         if (item3_ff.zero) begin
            status_ff <= STATUS_ZERO;
            temp_ff   <= '0;
            press_ff  <= '0;
            depth_ff  <= '0;
         end else if (item3_ff.over) begin
            status_ff <= STATUS_OVER;
            temp_ff   <= '0;
            press_ff  <= '0;
            depth_ff  <= '0;
         end else begin
            status_ff <= STATUS_OK;
            temp_ff   <= item3_ff.temp;
            press_ff  <= item3_ff.pr;
            depth_ff  <= depth_sel;
         end
      end
   end

   assign in_ready              = ready[0];
   assign out_valid             = valid_ff[DEPTH_STAGES-1];
   assign out_status            = status_ff;
   assign out_temperature_centi = temp_ff;
   assign out_pressure_mpa      = press_ff;
   assign out_depth_mm          = depth_ff;

endmodule

// ===== design/pressure_compensation_depth_core.sv =====
// Throughput: one item per cycle; every stage register advances when the one after it
// is empty or moving, so bubbles close up and req_stall rises only with all 12 stages full.
// Reset (synchronous, active high) clears every stage valid bit and sets all
// calibration and mode registers to zero.
`include "assert_macros.svh"

module pressure_compensation_depth_core
   import pcd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [RAW_W-1:0]         req_raw_pressure,
   input  logic [RAW_W-1:0]         req_raw_temperature,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic signed [TEMP_W-1:0] rsp_temperature_centi,
   output logic signed [MPA_W-1:0]  rsp_pressure_mpa,
   output logic signed [MPA_W-1:0]  rsp_depth_mm
);

   cfg_type       cfg_ff;
   logic          comp_ready;
   logic          comp_valid;
   comp_out_type  comp_data;
   logic          scale_ready;
   logic          scale_valid;
   scale_out_type scale_data;
   logic          depth_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_SENS:        cfg_ff.sens_coef           <= csr_wdata[COEF_W-1:0];
            REG_OFFSET:      cfg_ff.offset_coef         <= csr_wdata[COEF_W-1:0];
            REG_SENS_TEMP:   cfg_ff.sens_temp_coef      <= csr_wdata[COEF_W-1:0];
            REG_OFFSET_TEMP: cfg_ff.offset_temp_coef    <= csr_wdata[COEF_W-1:0];
            REG_TREF:        cfg_ff.tref_coef           <= csr_wdata[COEF_W-1:0];
            REG_TEMP_SENS:   cfg_ff.temp_sens_coef      <= csr_wdata[COEF_W-1:0];
            REG_MODE:        cfg_ff.sensor_mode         <= csr_wdata[0];
            REG_PRESS_OFF:   cfg_ff.pressure_offset_mpa <= $signed(csr_wdata[MPA_W-1:0]);
            default: begin
            end
         endcase
      end
   end

   pcd_comp u_comp (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .in_valid        (req_valid),
      .in_ready        (comp_ready),
      .raw_pressure    (req_raw_pressure),
      .raw_temperature (req_raw_temperature),
      .out_valid       (comp_valid),
      .out_ready       (scale_ready),
      .out_data        (comp_data)
   );

   pcd_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (comp_valid),
      .in_ready  (scale_ready),
      .in_data   (comp_data),
      .out_valid (scale_valid),
      .out_ready (depth_ready),
      .out_data  (scale_data)
   );

   pcd_depth u_depth (
      .clock                 (clock),
      .reset                 (reset),
      .in_valid              (scale_valid),
      .in_ready              (depth_ready),
      .in_data               (scale_data),
      .out_valid             (rsp_valid),
      .out_ready             (!rsp_stall),
      .out_status            (rsp_status),
      .out_temperature_centi (rsp_temperature_centi),
      .out_pressure_mpa      (rsp_pressure_mpa),
      .out_depth_mm          (rsp_depth_mm)
   );

   assign req_stall = !comp_ready;

   `ASSERT_IMPLY(a_stall_only_when_full, req_stall, rsp_valid && rsp_stall, "input stalled with room in pipeline")
   `ASSERT_IMPLY(a_error_zeroes, rsp_valid && (rsp_status != STATUS_OK), (rsp_temperature_centi == '0) && (rsp_pressure_mpa == '0) && (rsp_depth_mm == '0), "error item carries nonzero fields")
   `ASSERT_ALWAYS(a_water_depth_positive, !(rsp_valid && (rsp_status == STATUS_OK) && (rsp_pressure_mpa >= ATMO_MPA)) || (rsp_depth_mm >= 0), "negative depth under water")

endmodule

// ===== verif/tb_top.sv =====
// Testbench for pressure_compensation_depth_core: sends raw conversion pairs under
// several calibration settings, predicts each compensated reading and checks it.
// Depends on pcd_pkg and the core only.
module tb_top
   import pcd_pkg::*;
;

   localparam int HOLD_LIMIT  = 1000;
   localparam int DRAIN_SLACK = 24;
   localparam int REPORT_MAX  = 10;
   localparam logic [RAW_W-1:0] RAW_MAX = '1;

   localparam logic [RAW_W-1:0] LOW_D1  = 24'd9085466;
   localparam logic [RAW_W-1:0] LOW_D2  = 24'd8569150;
   localparam logic [RAW_W-1:0] HIGH_D1 = 24'd4958179;
   localparam logic [RAW_W-1:0] HIGH_D2 = 24'd6815414;
   localparam int MID_RAW = 8388608;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic signed [TEMP_W-1:0] temperature_centi;
      logic signed [MPA_W-1:0]  pressure_mpa;
      logic signed [MPA_W-1:0]  depth_mm;
   } reading_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata = '0;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [RAW_W-1:0]         req_raw_pressure = '0;
   logic [RAW_W-1:0]         req_raw_temperature = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [STATUS_W-1:0]      rsp_status;
   logic signed [TEMP_W-1:0] rsp_temperature_centi;
   logic signed [MPA_W-1:0]  rsp_pressure_mpa;
   logic signed [MPA_W-1:0]  rsp_depth_mm;

   cfg_type     calib = '0;
   reading_type awaited_readings[$];
   int          fail_count = 0;
   int          quiet_cycles = 0;
   bit          calm = 1'b0;

   pressure_compensation_depth_core dut (.*);

   always #5 clock = ~clock;

   function automatic reading_type compensate_reading(input logic [RAW_W-1:0] d1_raw,
                                                      input logic [RAW_W-1:0] d2_raw);
      reading_type r;
      longint      d1, d2, dt, temp, off, sens, p, pm, pr, depth;
      int          pr32;
      r = '0;
      if (d1_raw == '0 || d2_raw == '0) begin
         r.status = STATUS_ZERO;
         return r;
      end
      d1   = longint'(d1_raw);
      d2   = longint'(d2_raw);
      dt   = d2 - (longint'(calib.tref_coef) <<< 8);
      temp = ((dt * longint'(calib.temp_sens_coef)) >>> 23) + longint'(TEMP_BIAS);
      off  = (longint'(calib.offset_coef) <<< 16)
             + ((longint'(calib.offset_temp_coef) * dt) >>> 7);
      sens = (longint'(calib.sens_coef) <<< 15)
             + ((longint'(calib.sens_temp_coef) * dt) >>> 8);
      p    = ((sens * d1) >>> 21) - off;
      if (!calib.sensor_mode) begin
         pm = (p * 1000) >>> 15;
         if (pm > longint'(LOW_RANGE_LIMIT_MPA)) begin
            r.status = STATUS_OVER;
            return r;
         end
         pr32 = int'(pm);
      end else begin
         pm   = (p * 10000) >>> 13;
         pr32 = int'(pm) + calib.pressure_offset_mpa;
      end
      pr = longint'(pr32);
      if (pr < longint'(ATMO_MPA))
         depth = -((pr * longint'(AIR_A) + longint'(AIR_B)) >>> 26);
      else
         depth = (pr - longint'(ATMO_MPA)) / longint'(WATER_DIV);
      r.status            = STATUS_OK;
      r.temperature_centi = temp[TEMP_W-1:0];
      r.pressure_mpa      = pr32;
      r.depth_mm          = depth[MPA_W-1:0];
      return r;
   endfunction

   function automatic void check_field(input string name, input longint want,
                                       input longint got);
      if (want != got) begin
         fail_count++;
         if (fail_count <= REPORT_MAX)
            $display("mismatch on %s: expected %0d, got %0d", name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      reading_type want;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write)
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (req_valid && !req_stall)
            awaited_readings.push_back(
               compensate_reading(req_raw_pressure, req_raw_temperature));
         if (rsp_valid && !rsp_stall) begin
            if (awaited_readings.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_MAX)
                  $display("unexpected item: status %0d pressure %0d depth %0d",
                           rsp_status, rsp_pressure_mpa, rsp_depth_mm);
            end else begin
               want = awaited_readings.pop_front();
               check_field("status", longint'(want.status), longint'(rsp_status));
               check_field("temperature_centi", longint'(want.temperature_centi),
                           longint'(rsp_temperature_centi));
               check_field("pressure_mpa", longint'(want.pressure_mpa),
                           longint'(rsp_pressure_mpa));
               check_field("depth_mm", longint'(want.depth_mm), longint'(rsp_depth_mm));
            end
         end
      end
   end

   initial begin
      while (quiet_cycles < HOLD_LIMIT) @(posedge clock);
      $display("tb_top failed");
      $finish;
   end

   always begin
      @(negedge clock);
      if (!calm && !reset) begin
         if ($urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 15) == 0) begin
            repeat ($urandom_range(20, 60)) @(negedge clock);
         end
      end
   end

   task automatic send_reading(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
      @(negedge clock);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_raw_pressure    <= d1;
      req_raw_temperature <= d2;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      wait_drained();
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         REG_SENS:        calib.sens_coef           = data[COEF_W-1:0];
         REG_OFFSET:      calib.offset_coef         = data[COEF_W-1:0];
         REG_SENS_TEMP:   calib.sens_temp_coef      = data[COEF_W-1:0];
         REG_OFFSET_TEMP: calib.offset_temp_coef    = data[COEF_W-1:0];
         REG_TREF:        calib.tref_coef           = data[COEF_W-1:0];
         REG_TEMP_SENS:   calib.temp_sens_coef      = data[COEF_W-1:0];
         REG_MODE:        calib.sensor_mode         = data[0];
         REG_PRESS_OFF:   calib.pressure_offset_mpa = data;
         default: begin
         end
      endcase
   endtask

   // upper bits of the narrow registers carry noise and must be dropped
   task automatic program_calibration(input logic [COEF_W-1:0] c1, c2, c3, c4, c5, c6,
                                      input logic mode, input logic [MPA_W-1:0] offset);
      write_reg(REG_SENS,        {16'($urandom), c1});
      write_reg(REG_OFFSET,      {16'($urandom), c2});
      write_reg(REG_SENS_TEMP,   {16'($urandom), c3});
      write_reg(REG_OFFSET_TEMP, {16'($urandom), c4});
      write_reg(REG_TREF,        {16'($urandom), c5});
      write_reg(REG_TEMP_SENS,   {16'($urandom), c6});
      write_reg(REG_MODE,        {31'($urandom), mode});
      write_reg(REG_PRESS_OFF,   offset);
   endtask

   function automatic logic [RAW_W-1:0] raw_around(input int centre, input int spread);
      int v;
      case ($urandom_range(0, 19))
         0: return '0;
         1: return RAW_MAX;
         2, 3, 4, 5: return RAW_W'($urandom);
         default: begin
            v = centre + int'($urandom_range(0, 2 * spread)) - spread;
            if (v < 1) v = 1;
            if (v > int'(RAW_MAX)) v = int'(RAW_MAX);
            return RAW_W'(v);
         end
      endcase
   endfunction

   task automatic send_batch(input int count, input int d1_centre, input int d2_centre,
                             input int spread);
      repeat (count)
         send_reading(raw_around(d1_centre, spread), raw_around(d2_centre, spread));
   endtask

   task automatic test_power_on_defaults();
      send_reading(1, 1);
      send_reading(RAW_MAX, RAW_MAX);
      send_reading('0, 5);
      send_reading(12345, '0);
   endtask

   task automatic test_directed_low_range();
      program_calibration(40127, 36924, 23317, 23282, 33464, 28312, 1'b0, 32'h7FFF_FFFF);
      send_reading(LOW_D1, LOW_D2);
      send_reading(7000000, LOW_D2);
      send_reading(10500000, LOW_D2);
      send_reading(11000000, LOW_D2);
      send_reading('0, LOW_D2);
      send_reading(LOW_D1, '0);
      send_reading('0, '0);
      send_reading(RAW_MAX, RAW_MAX);
      send_reading(1, 1);
      send_reading(1, RAW_MAX);
      send_reading(RAW_MAX, 1);
   endtask

   task automatic test_directed_high_range();
      program_calibration(34982, 36352, 20328, 22354, 26646, 26146, 1'b1, '0);
      send_reading(HIGH_D1, HIGH_D2);
      send_reading(4400000, HIGH_D2);
      send_reading(RAW_MAX, RAW_MAX);
      send_reading(1, 1);
      write_reg(REG_PRESS_OFF, 32'h7FFF_FFFF);
      send_reading(HIGH_D1, HIGH_D2);
      write_reg(REG_PRESS_OFF, 32'h8000_0000);
      send_reading(HIGH_D1, HIGH_D2);
      send_reading(RAW_MAX, 1);
   endtask

   task automatic test_random_low_range();
      program_calibration(40127, 36924, 23317, 23282, 33464, 28312, 1'b0, $urandom);
      send_batch(250, int'(LOW_D1), int'(LOW_D2), 2000000);
   endtask

   task automatic test_random_high_range();
      program_calibration(34982, 36352, 20328, 22354, 26646, 26146, 1'b1,
                          32'($urandom_range(0, 400000000)) - 32'd200000000);
      send_batch(250, int'(HIGH_D1), int'(HIGH_D2), 1000000);
   endtask

   task automatic test_extreme_coefficients();
      program_calibration('1, '1, '1, '1, '1, '1, 1'b0, 32'h7FFF_FFFF);
      send_batch(120, MID_RAW, MID_RAW, MID_RAW - 1);
      program_calibration('1, '1, '1, '1, '1, '1, 1'b1, 32'h8000_0000);
      send_batch(120, MID_RAW, MID_RAW, MID_RAW - 1);
      program_calibration('0, '0, '0, '0, '0, '0, 1'b1, 32'h7FFF_FFFF);
      send_batch(120, MID_RAW, MID_RAW, MID_RAW - 1);
      program_calibration('0, '0, '0, '1, '1, '1, 1'b0, 32'h8000_0000);
      send_batch(120, MID_RAW, MID_RAW, MID_RAW - 1);
   endtask

   task automatic test_random_coefficients();
      repeat (3) begin
         program_calibration(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom), 1'($urandom), $urandom);
         send_batch(80, MID_RAW, MID_RAW, MID_RAW - 1);
      end
   endtask

   // full rate on both sides, with one restart from an empty pipeline
   task automatic test_full_rate();
      program_calibration(34982, 36352, 20328, 22354, 26646, 26146, 1'b1, '0);
      calm = 1'b1;
      send_batch(125, int'(HIGH_D1), int'(HIGH_D2), 1000000);
      wait_drained();
      send_batch(125, int'(HIGH_D1), int'(HIGH_D2), 1000000);
   endtask

   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      test_power_on_defaults();
      test_directed_low_range();
      test_directed_high_range();
      test_random_low_range();
      test_random_high_range();
      test_extreme_coefficients();
      test_random_coefficients();
      test_full_rate();
      wait_drained();
      if (fail_count == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
